// ===== rtl/core/bcsf_pkg.sv =====
// Shared types and constants for the binary cross stencil filter.
// No dependencies; used by the top level, bcsf_pos and bcsf_window.
package bcsf_pkg;

  // Filter mode codes
  localparam logic MODE_BRIDGE = 1'b0;
  localparam logic MODE_SPUR   = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Configuration field widths
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_WIDTH_W  = 11;
  localparam int unsigned CFG_HEIGHT_W = 13;

  // Pixel codes
  localparam int unsigned PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_SET   = 8'd255;
  localparam logic [PIX_W-1:0] PIX_CLEAR = 8'd0;

  // Smallest accepted image size in either direction
  localparam int unsigned MIN_SIZE = 3;

  // Per-word position flags handed from the counters to the window stage
  typedef struct packed {
    logic emit;   // interior pixel, a result word follows
    logic last;   // final interior pixel of the frame
  } pos_flags_t;

endpackage

// ===== rtl/core/binary_cross_stencil_filter_top.sv =====
// Binary cross stencil filter, top level: configuration registers, counters,
// line buffer RAM and window stage. Depends on bcsf_pkg, bcsf_ram, bcsf_pos, bcsf_window.
//
// Usage:
//   Input words (in_*) carry one 8-bit grey pixel each in raster order; any
//   non-zero value counts as set. Output words (out_*) carry one filtered
//   pixel (0 or 255) for each interior pixel, i.e. not in the first or last
//   row or column; out_tlast marks the last interior pixel of the frame.
//   The result for pixel (r-1,c-1) is produced by the word carrying (r,c).
//   An accepted word is registered in the window stage, its result in the
//   output register. Throughput: one word per cycle unless the receiver
//   stalls, set by the separate read and write ports of the line buffer RAM
//   (read on accept, write back at a different column as the stage drains).
//   When the receiver stalls, one finished word waits in the output register,
//   one more in the window stage, and in_tready drops only when both are full
//   (border words pass through without needing the output slot).
//   Reset clears counters, window and handshake state and loads mode 0
//   (bridge), width 640 and height 480, clamped to size limits. Line buffers
//   are not cleared; the first two rows fill them before use. The user must
//   write configuration (cfg_*) only while no words are in flight; unenforced.
module binary_cross_stencil_filter_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] pixel_value
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [7:0]                        out_tdata,  // [7:0] output_pixel
  output logic                              out_tlast,  // frame_last
  // configuration write port
  input  logic                              cfg_we,
  input  logic [bcsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bcsf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RESET = (640 > MAX_WIDTH) ? MAX_WIDTH : 640;
  localparam int unsigned H_RESET = (480 > MAX_HEIGHT) ? MAX_HEIGHT : 480;

  logic          mode_r;
  logic [WW-1:0] width_r;
  logic [HW-1:0] height_r;
  logic [31:0]   wv, hv;
  logic [WW-1:0] width_clamped;
  logic [HW-1:0] height_clamped;

  // Clamp sizes on write; only the clamped value is ever used
  always_comb begin
    wv = 32'(cfg_wdata[bcsf_pkg::CFG_WIDTH_W-1:0]);
    hv = 32'(cfg_wdata[bcsf_pkg::CFG_HEIGHT_W-1:0]);
    priority if (wv < 32'(bcsf_pkg::MIN_SIZE)) begin
      width_clamped = WW'(bcsf_pkg::MIN_SIZE);
    end else if (wv > 32'(MAX_WIDTH)) begin
      width_clamped = WW'(MAX_WIDTH);
    end else begin
      width_clamped = wv[WW-1:0];
    end
    priority if (hv < 32'(bcsf_pkg::MIN_SIZE)) begin
      height_clamped = HW'(bcsf_pkg::MIN_SIZE);
    end else if (hv > 32'(MAX_HEIGHT)) begin
      height_clamped = HW'(MAX_HEIGHT);
    end else begin
      height_clamped = hv[HW-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= bcsf_pkg::MODE_BRIDGE;
      width_r  <= WW'(W_RESET);
      height_r <= HW'(H_RESET);
    end else if (cfg_we) begin
      if (cfg_index == bcsf_pkg::REG_FILTER_MODE) begin
        mode_r <= cfg_wdata[0];
      end
      if (cfg_index == bcsf_pkg::REG_IMAGE_WIDTH) begin
        width_r <= width_clamped;
      end
      if (cfg_index == bcsf_pkg::REG_IMAGE_HEIGHT) begin
        height_r <= height_clamped;
      end
    end
  end

  logic                 in_acc;
  logic [CW-1:0]        col_idx;
  bcsf_pkg::pos_flags_t pos_flags;
  logic                 ram_we;
  logic [CW-1:0]        ram_waddr;
  logic [1:0]           ram_wdata, ram_rdata;

  assign in_acc = in_tvalid && in_tready;

  // Position counters
  bcsf_pos #(
    .CW (CW),
    .RW (RW),
    .WW (WW),
    .HW (HW)
  ) u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .img_w   (width_r),
    .img_h   (height_r),
    .col_idx (col_idx),
    .flags   (pos_flags)
  );

  // Line buffers: bit 0 row two above, bit 1 row just above
  bcsf_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_lines (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (col_idx),
    .rdata (ram_rdata)
  );

  // Window, decision and output register
  bcsf_window #(
    .AW (CW)
  ) u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_bit    (in_tdata != 8'd0),
    .in_flags  (pos_flags),
    .in_idx    (col_idx),
    .in_ready  (in_tready),
    .ram_rdata (ram_rdata),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .mode      (mode_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== rtl/core/bcsf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bcsf_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/bcsf_pos.sv =====
// Column/row counters: position of the incoming word and its result flags.
// Depends on bcsf_pkg.
module bcsf_pos #(
  parameter int unsigned CW = 10,  // column counter bits
  parameter int unsigned RW = 12,  // row counter bits
  parameter int unsigned WW = 11,  // effective width bits
  parameter int unsigned HW = 13   // effective height bits
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_acc,
  input  logic [WW-1:0]       img_w,
  input  logic [HW-1:0]       img_h,
  output logic [CW-1:0]       col_idx,
  output bcsf_pkg::pos_flags_t flags
);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;

  // Compare in one bit more than the counters so limits and c+1 fit
  logic [CW:0] cx, cx_inc, wx;
  logic [RW:0] rx, rx_inc, hx;

  always_comb begin
    cx     = {1'b0, col_r};
    cx_inc = cx + 1'b1;
    wx     = (CW+1)'(img_w);
    rx     = {1'b0, row_r};
    rx_inc = rx + 1'b1;
    hx     = (RW+1)'(img_h);
  end

  // Result flags for the word being accepted
  always_comb begin
    flags.emit = (rx >= (RW+1)'(2)) && (cx >= (CW+1)'(2)) && (rx < hx) && (cx < wx);
    flags.last = (rx == hx - 1'b1) && (cx == wx - 1'b1);
  end

  assign col_idx = col_r;

  // Raster advance with wrap at the configured limits
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (cx_inc >= wx) begin
        col_nxt = '0;
        row_nxt = (rx_inc >= hx) ? '0 : rx_inc[RW-1:0];
      end else begin
        col_nxt = cx_inc[CW-1:0];
        row_nxt = (rx >= hx) ? '0 : row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== rtl/core/bcsf_window.sv =====
// Window stage: 3x3 bit window, stencil decision, line buffer write-back
// and the output register with its handshake. Depends on bcsf_pkg.
module bcsf_window #(
  parameter int unsigned AW = 10
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_acc,
  input  logic                        in_bit,
  input  bcsf_pkg::pos_flags_t        in_flags,
  input  logic [AW-1:0]               in_idx,
  output logic                        in_ready,
  input  logic [1:0]                  ram_rdata,  // bit 0 upper, bit 1 middle
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [1:0]                  ram_wdata,
  input  logic                        mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bcsf_pkg::PIX_W-1:0]  out_data,
  output logic                        out_last
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_bit_r;
  bcsf_pkg::pos_flags_t  s1_flags_r;
  logic [AW-1:0]         s1_idx_r;
  logic [8:0]            window_r, window_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [bcsf_pkg::PIX_W-1:0] out_data_r;
  logic                  out_last_r;

  logic out_free, s1_move, s1_emit;
  logic centre, up, down, left, right, set_bit;

  // Stage handshake: the stage drains when its word needs no output slot or the slot is free
  always_comb begin
    out_free = !out_valid_r || out_ready;
    s1_move  = s1_valid_r && (!s1_flags_r.emit || out_free);
    s1_emit  = s1_move && s1_flags_r.emit;
    in_ready = !s1_valid_r || s1_move;
  end

  // New column {pixel, middle, upper} enters at the top, oldest drops out
  always_comb begin
    window_nxt = {s1_bit_r, ram_rdata[1], ram_rdata[0], window_r[8:3]};
    centre = window_nxt[4];
    up     = window_nxt[3];
    down   = window_nxt[5];
    left   = window_nxt[1];
    right  = window_nxt[7];
    unique case (mode)
      bcsf_pkg::MODE_BRIDGE: set_bit = centre | (up & down) | (left & right);
      bcsf_pkg::MODE_SPUR:   set_bit = centre & (up | down | left | right);
      default:               set_bit = centre;
    endcase
  end

  // Line buffers shift down one row at this column
  assign ram_we    = s1_move;
  assign ram_waddr = s1_idx_r;
  assign ram_wdata = {s1_bit_r, ram_rdata[1]};

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      window_r    <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_move) begin
        window_r <= window_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_bit_r   <= in_bit;
      s1_flags_r <= in_flags;
      s1_idx_r   <= in_idx;
    end
    if (s1_emit) begin
      out_data_r <= set_bit ? bcsf_pkg::PIX_SET : bcsf_pkg::PIX_CLEAR;
      out_last_r <= s1_flags_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

  // An accepted word always lands in the window stage
  a_acc_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_valid_r)
    else $error("accepted word did not reach window stage");

  // Frame end is only ever flagged on an interior pixel
  a_last_interior: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_flags_r.last |-> s1_flags_r.emit)
    else $error("frame end flagged on a border pixel");

  // Result words carry only the two binary codes
  a_binary_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r == bcsf_pkg::PIX_SET) || (out_data_r == bcsf_pkg::PIX_CLEAR))
    else $error("result word is not binary");

endmodule

// ===== dv/binary_cross_stencil_filter_top_tb.sv =====
// Self-checking bench for binary_cross_stencil_filter_top: streams pixels through the
// cleanup filter and checks each result word against a bit-exact window predictor.
// Depends on bcsf_pkg and the filter RTL.
`timescale 1ns / 1ps

module binary_cross_stencil_filter_top_tb;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int unsigned RAND_ITEMS  = 1950;

  // Predicts the filtered words and checks what comes out of the block
  class cleanup_scoreboard;
    localparam int unsigned LINE_W  = 1024;
    localparam int unsigned FRAME_H = 4096;

    typedef struct {
      logic [bcsf_pkg::PIX_W-1:0] pix;
      logic                       last;
    } filtered_word_t;

    bit                upper_row [LINE_W];
    bit                middle_row[LINE_W];
    byte unsigned      fill_cnt  [LINE_W];  // writes per column, saturates at 2
    logic [8:0]        window;              // three columns of three bits, oldest low
    int unsigned       col;
    int unsigned       row;
    logic              mode;
    logic [10:0]       width_reg;
    logic [12:0]       height_reg;
    filtered_word_t    expected_words[$];
    int unsigned       mismatches;

    function new();
      foreach (upper_row[i]) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
        fill_cnt[i]   = 0;
      end
      window     = '0;
      col        = 0;
      row        = 0;
      mode       = bcsf_pkg::MODE_BRIDGE;
      width_reg  = 11'd640;
      height_reg = 13'd480;
      mismatches = 0;
    endfunction

    function int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < bcsf_pkg::MIN_SIZE) return bcsf_pkg::MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function void apply_reg(logic [bcsf_pkg::CFG_IDX_W-1:0] idx,
                            logic [bcsf_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        bcsf_pkg::REG_FILTER_MODE:  mode = val[0];
        bcsf_pkg::REG_IMAGE_WIDTH:  width_reg = val[10:0];
        bcsf_pkg::REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // A wider row must never pull a line-buffer entry that was never written
    function bit width_safe(logic [10:0] raw);
      int unsigned cw;
      cw = clamp_dim(raw, LINE_W);
      if (cw <= clamp_dim(width_reg, LINE_W)) return 1'b1;
      if (col == 0 && row == 0) return 1'b1;
      for (int unsigned i = 0; i < cw; i++)
        if (fill_cnt[i] < 2) return 1'b0;
      return 1'b1;
    endfunction

    function int unsigned outstanding();
      return expected_words.size();
    endfunction

    // One accepted pixel: shift the window, update the lines, maybe queue a word
    function void take_pixel(logic [bcsf_pkg::PIX_W-1:0] v);
      int unsigned    w, h, c, r, idx;
      logic           p, hit;
      logic [2:0]     fresh;
      filtered_word_t word;
      w   = clamp_dim(width_reg, LINE_W);
      h   = clamp_dim(height_reg, FRAME_H);
      c   = col;
      r   = row;
      p   = (v != '0);
      idx = (c < LINE_W) ? c : LINE_W - 1;
      fresh  = {p, middle_row[idx], upper_row[idx]};
      window = {fresh, window[8:3]};
      upper_row[idx]  = middle_row[idx];
      middle_row[idx] = p;
      if (fill_cnt[idx] < 2) fill_cnt[idx]++;

      // interior pixel one row up and one column left
      if (r >= 2 && c >= 2 && r < h && c < w) begin
        if (mode == bcsf_pkg::MODE_BRIDGE)
          hit = window[4] | (window[3] & window[5]) | (window[1] & window[7]);
        else
          hit = window[4] & (window[3] | window[5] | window[1] | window[7]);
        word.pix  = hit ? bcsf_pkg::PIX_SET : bcsf_pkg::PIX_CLEAR;
        word.last = (r == h - 1 && c == w - 1);
        expected_words.push_back(word);
      end

      // raster position, with wrap past a limit that shrank mid-frame
      if (c + 1 >= w) begin
        col = 0;
        row = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col = c + 1;
        row = (r >= h) ? 0 : r;
      end
    endfunction

    task report(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_word(logic [bcsf_pkg::PIX_W-1:0] pix, logic last);
      filtered_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %0d/%0b with nothing expected", pix, last));
        return;
      end
      want = expected_words.pop_front();
      if (pix !== want.pix)
        report($sformatf("output_pixel %0d, expected %0d", pix, want.pix));
      if (last !== want.last)
        report($sformatf("frame_last %0b, expected %0b", last, want.last));
    endtask
  endclass

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [7:0]                      in_tdata   = '0;
  logic                            out_tready = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [bcsf_pkg::CFG_IDX_W-1:0]  cfg_index  = bcsf_pkg::REG_FILTER_MODE;
  logic [bcsf_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [7:0]                      out_tdata;
  logic                            out_tlast;

  cleanup_scoreboard sb = new();
  bit                steady = 1'b0;     // no idling on either side while set
  int unsigned       sent = 0;
  int unsigned       quiet_cycles = 0;

  // directed frames: horizontal bridge, then isolated and paired spur pixels
  byte unsigned bridge_frame[9]  = '{0, 1, 0, 128, 0, 255, 0, 0, 0};
  byte unsigned spur_frame  [15] = '{0, 0, 0, 0, 0, 0, 200, 0, 33, 34, 0, 0, 0, 0, 0};

  binary_cross_stencil_filter_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(negedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 8);
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
  end

  // watchdog: ends a run where no word moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task send_pixel(logic [7:0] v);
    int unsigned gap;
    gap = 0;
    if (!steady && $urandom_range(99) < 8) gap = 1;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    do @(posedge clk); while (!in_tready);
    sb.take_pixel(v);
    sent++;
  endtask

  // stop sending, wait for every expected word, then let border words flush
  task drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task write_reg(logic [bcsf_pkg::CFG_IDX_W-1:0] idx, logic [bcsf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.apply_reg(idx, val);
  endtask

  // mostly small rows, some below the minimum, a few at the clamp ceiling
  function logic [bcsf_pkg::CFG_DATA_W-1:0] pick_width();
    int unsigned k;
    logic [bcsf_pkg::CFG_DATA_W-1:0] v;
    k = $urandom_range(99);
    if (k < 60)      v = 13'($urandom_range(3, 10));
    else if (k < 72) v = 13'($urandom_range(0, 2));
    else if (k < 85) v = 13'($urandom_range(11, 48));
    else             v = 13'($urandom_range(1000, 2047));
    if ($urandom_range(3) == 0) v[12:11] = 2'($urandom_range(1, 3));
    return v;
  endfunction

  function logic [bcsf_pkg::CFG_DATA_W-1:0] pick_height();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 55) return 13'($urandom_range(3, 8));
    if (k < 70) return 13'($urandom_range(0, 2));
    if (k < 85) return 13'($urandom_range(9, 40));
    return 13'($urandom_range(4000, 8191));
  endfunction

  initial begin
    int unsigned phase, n, pct;
    logic [bcsf_pkg::CFG_DATA_W-1:0] v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frames
    write_reg(bcsf_pkg::REG_FILTER_MODE, 13'(bcsf_pkg::MODE_BRIDGE));
    write_reg(bcsf_pkg::REG_IMAGE_WIDTH, 13'd3);
    write_reg(bcsf_pkg::REG_IMAGE_HEIGHT, 13'd3);
    foreach (bridge_frame[i]) send_pixel(bridge_frame[i]);
    drain();
    write_reg(bcsf_pkg::REG_FILTER_MODE, 13'(bcsf_pkg::MODE_SPUR));
    // upper bits beyond the register dropped
    write_reg(bcsf_pkg::REG_IMAGE_WIDTH, {2'b11, 11'd5});
    foreach (spur_frame[i]) send_pixel(spur_frame[i]);
    drain();

    // random phases, each starting from an idle block
    phase = 0;
    while (sent < RAND_ITEMS + 24) begin
      drain();
      if (phase == 0) begin
        write_reg(bcsf_pkg::REG_IMAGE_WIDTH, 13'h7FF);
        write_reg(bcsf_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
        write_reg(bcsf_pkg::REG_FILTER_MODE, 13'($urandom_range(0, 1)));
        n = 300;
      end else begin
        if ($urandom_range(2) == 0)
          write_reg(bcsf_pkg::REG_FILTER_MODE, 13'($urandom_range(0, 8191)));
        if (phase == 1) begin
          write_reg(bcsf_pkg::REG_IMAGE_WIDTH, 13'($urandom_range(3, 10)));
        end else if ($urandom_range(1) == 0) begin
          v = pick_width();
          if (sb.width_safe(v[10:0])) write_reg(bcsf_pkg::REG_IMAGE_WIDTH, v);
        end
        if ($urandom_range(1) == 0) write_reg(bcsf_pkg::REG_IMAGE_HEIGHT, pick_height());
        n = $urandom_range(20, 160);
      end
      pct    = $urandom_range(5, 95);
      steady = (phase >= 6 && phase < 9);
      repeat (n) begin
        if ($urandom_range(9) == 0)
          send_pixel(8'($urandom));
        else
          send_pixel(($urandom_range(99) < pct) ? 8'($urandom_range(1, 255)) : 8'd0);
      end
      phase++;
    end
    steady = 1'b0;
    drain();

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
